// ===== sv/dnc_pkg.sv =====
// ----------------------------------------------------------------------------
// dnc_pkg
// Types, calendar constants and small lookup functions for the day number
// to calendar date decoder.
// ----------------------------------------------------------------------------
package dnc_pkg;

  localparam int unsigned EPOCH_OFFSET = 693594;
  localparam int unsigned LAST_VALID_T = 3652059;
  localparam int unsigned D1           = 365;
  localparam int unsigned D4           = D1 * 4 + 1;
  localparam int unsigned D100         = D4 * 25 - 1;
  localparam int unsigned D400         = D100 * 4 + 1;

  localparam int unsigned REM_W        = 22;
  localparam int unsigned YEAR_W       = 14;
  localparam int unsigned DIV_STEPS    = 14;
  localparam int unsigned LAST_MONTH   = 11;

  typedef struct packed {
    logic signed [22:0] day_number;
  } day_in_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [2:0]  weekday;
    logic        leap_year;
    logic        valid_res;
  } date_out_t;

  // divisor for each restoring step: 400-year bits, 100-year bits,
  // 4-year bits, then single-year bits
  function automatic logic [REM_W-1:0] step_divisor(input logic [3:0] idx);
    case (idx)
      4'd0:    return REM_W'(D400 * 16);
      4'd1:    return REM_W'(D400 * 8);
      4'd2:    return REM_W'(D400 * 4);
      4'd3:    return REM_W'(D400 * 2);
      4'd4:    return REM_W'(D400);
      4'd5:    return REM_W'(D100 * 2);
      4'd6:    return REM_W'(D100);
      4'd7:    return REM_W'(D4 * 16);
      4'd8:    return REM_W'(D4 * 8);
      4'd9:    return REM_W'(D4 * 4);
      4'd10:   return REM_W'(D4 * 2);
      4'd11:   return REM_W'(D4);
      4'd12:   return REM_W'(D1 * 2);
      4'd13:   return REM_W'(D1);
      default: return '0;
    endcase
  endfunction

  // years added when the matching step subtracts
  function automatic logic [YEAR_W-1:0] step_years(input logic [3:0] idx);
    case (idx)
      4'd0:    return YEAR_W'(6400);
      4'd1:    return YEAR_W'(3200);
      4'd2:    return YEAR_W'(1600);
      4'd3:    return YEAR_W'(800);
      4'd4:    return YEAR_W'(400);
      4'd5:    return YEAR_W'(200);
      4'd6:    return YEAR_W'(100);
      4'd7:    return YEAR_W'(64);
      4'd8:    return YEAR_W'(32);
      4'd9:    return YEAR_W'(16);
      4'd10:   return YEAR_W'(8);
      4'd11:   return YEAR_W'(4);
      4'd12:   return YEAR_W'(2);
      4'd13:   return YEAR_W'(1);
      default: return '0;
    endcase
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    case (m) inside
      4'd1:                   return leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: return 5'd30;
      default:                return 5'd31;
    endcase
  endfunction

  // v is below 28
  function automatic logic [2:0] mod7_small(input logic [4:0] v);
    logic [4:0] a;
    logic [4:0] b;
    a = (v >= 5'd14) ? v - 5'd14 : v;
    b = (a >= 5'd7) ? a - 5'd7 : a;
    return b[2:0];
  endfunction

endpackage

// ===== sv/dnc_stream_if.sv =====
// ----------------------------------------------------------------------------
// dnc_stream_if
// Valid/ready stream channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface dnc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/day_number_to_calendar_date.sv =====
// ----------------------------------------------------------------------------
// day_number_to_calendar_date
// Decodes a signed day number (day 0 is 1899-12-30) into year, month, day,
// weekday and leap flag of the proleptic Gregorian calendar.
//
// day_in carries one day number per transaction, date_out one decoded date.
// day_in.ready is high only while the decoder is idle; one transaction is
// worked on at a time.
// A single subtractor does all the work: 14 restoring steps peel off the
// 400-, 100-, 4- and 1-year blocks, then the month walk takes one step per
// month passed (0 to 11). A 2-bit-per-cycle mod-7 runs beside it for the
// weekday. A day number out of range skips both steps and yields an all-zero
// result.
// The result sits in an output register, so a new day number is taken while
// the previous date waits; if date_out is stalled when the next decode ends,
// the decoder holds in its final state until the register frees.
// Synchronous reset returns the sequencer to idle and drops date_out.valid.
// ----------------------------------------------------------------------------
module day_number_to_calendar_date (
  input  logic              clk,
  input  logic              rst,
  dnc_stream_if.sink        day_in,
  dnc_stream_if.source      date_out
);
  import dnc_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DIV   = 2'd1;
  localparam logic [1:0] S_MONTH = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]        state;
  logic [REM_W-1:0]  rem;
  logic [3:0]        step;
  logic [13:0]       qbits;
  logic [YEAR_W-1:0] year;
  logic [3:0]        mon;
  logic              ok;
  logic [REM_W-1:0]  tsr;
  logic [2:0]        wrem;
  logic [3:0]        wcnt;
  logic              ov;
  date_out_t         obuf;

  logic signed [23:0] t;
  logic               t_ok;
  logic [REM_W-1:0]   sub_val;
  logic [REM_W:0]     diff;
  logic               ge;
  logic               leap;
  logic [1:0]         q100;
  logic [4:0]         q4;
  logic [1:0]         q1;

  assign t    = 24'(day_in.data.day_number) + 24'(EPOCH_OFFSET);
  assign t_ok = !t[23] && (t != 24'sd0) && (t <= 24'(LAST_VALID_T));

  // quotient bits are stored msb first: 400s, 100s, 4s, 1s
  assign q100 = qbits[8:7];
  assign q4   = qbits[6:2];
  assign q1   = qbits[1:0];
  assign leap = (q1 == 2'd3) && ((q4 != 5'd24) || (q100 == 2'd3));

  assign sub_val = (state == S_MONTH) ? REM_W'(month_days(mon, leap)) : step_divisor(step);
  assign diff    = {1'b0, rem} - {1'b0, sub_val};
  assign ge      = !diff[REM_W];

  assign day_in.ready   = (state == S_IDLE);
  assign date_out.valid = ov;
  assign date_out.data  = obuf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ov    <= 1'b0;
      wcnt  <= '0;
    end else begin
      if (date_out.ready && (state != S_DONE)) begin
        ov <= 1'b0;
      end
      if ((state == S_DIV) && (wcnt != 4'd0)) begin
        wrem <= mod7_small({wrem, tsr[REM_W-1 -: 2]});
        tsr  <= {tsr[REM_W-3:0], 2'b00};
        wcnt <= wcnt - 4'd1;
      end
      unique case (state)
        S_IDLE: begin
          if (day_in.valid) begin
            ok    <= t_ok;
            rem   <= t[REM_W-1:0] - REM_W'(1);
            step  <= '0;
            qbits <= '0;
            year  <= YEAR_W'(1);
            tsr   <= t[REM_W-1:0];
            wrem  <= '0;
            wcnt  <= 4'(REM_W / 2);
            state <= t_ok ? S_DIV : S_DONE;
          end
        end
        S_DIV: begin
          if (ge) begin
            rem                 <= diff[REM_W-1:0];
            year                <= year + step_years(step);
            qbits[4'd13 - step] <= 1'b1;
          end
          if (step == 4'(DIV_STEPS - 1)) begin
            mon   <= '0;
            state <= S_MONTH;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_MONTH: begin
          if ((mon != 4'(LAST_MONTH)) && ge) begin
            rem <= diff[REM_W-1:0];
            mon <= mon + 4'd1;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!ov || date_out.ready) begin
            ov    <= 1'b1;
            state <= S_IDLE;
            if (ok) begin
              obuf.year         <= year;
              obuf.month        <= mon + 4'd1;
              obuf.day_of_month <= rem[4:0] + 5'd1;
              obuf.weekday      <= wrem + 3'd1;
              obuf.leap_year    <= leap;
              obuf.valid_res    <= 1'b1;
            end else begin
              obuf <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
